// ===== src/dftu_pkg.sv =====
// ----------------------------------------------------------------------------
// Deduplication fingerprint table package
// Shared sizes, entry layout, result codes and controller states.
// ----------------------------------------------------------------------------
package dftu_pkg;

  localparam int unsigned TABLE_ENTRIES    = 64;
  localparam int unsigned FINGERPRINT_BITS = 64;

  localparam int unsigned IDX_W      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W      = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned FP_IN_W    = 64;
  localparam int unsigned SHARE_W    = 16;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned ACTION_W   = 3;

  localparam int unsigned S_TDATA_W  = 2 * ADDR_W + FP_IN_W;
  localparam int unsigned M_FIELDS_W = ACTION_W + 2 * ADDR_W + SLOT_OUT_W + 1;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_UNCHANGED    = 3'd0,
    ACT_UPDATED      = 3'd1,
    ACT_REDIR_CHANGE = 3'd2,
    ACT_REDIR_NEW    = 3'd3,
    ACT_STORED       = 3'd4,
    ACT_FULL         = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [SHARE_W-1:0]          shares;
    logic [FINGERPRINT_BITS-1:0] fp;
    logic [ADDR_W-1:0]           inode;
    logic [ADDR_W-1:0]           client;
  } entry_t;

  typedef struct packed {
    logic               a_hit;
    logic               a_fp_eq;
    logic [IDX_W-1:0]   a_idx;
    logic [SHARE_W-1:0] a_shares;
    logic               f_hit;
    logic [IDX_W-1:0]   f_idx;
    logic [ADDR_W-1:0]  f_client;
    logic [ADDR_W-1:0]  f_inode;
    logic [SHARE_W-1:0] f_shares;
  } match_t;

  function automatic logic [SHARE_W-1:0] sat_inc(input logic [SHARE_W-1:0] v);
    sat_inc = (v == {SHARE_W{1'b1}}) ? v : v + SHARE_W'(1);
  endfunction

endpackage

// ===== src/dftu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dftu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/dftu_match.sv =====
// ----------------------------------------------------------------------------
// Fingerprint table match unit
// Compares each entry read during a scan with the search key and keeps the
// first address hit and the first fingerprint hit together with their data.
// ----------------------------------------------------------------------------
module dftu_match import dftu_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        vld_i,
  input  logic [IDX_W-1:0]            idx_i,
  input  entry_t                      entry_i,
  input  logic [ADDR_W-1:0]           key_client_i,
  input  logic [ADDR_W-1:0]           key_inode_i,
  input  logic [FINGERPRINT_BITS-1:0] key_fp_i,
  output match_t                      match_o
);

  match_t match_q, match_d;
  logic   addr_eq, fp_eq;

  assign addr_eq = (entry_i.client == key_client_i) && (entry_i.inode == key_inode_i);
  assign fp_eq   = (entry_i.fp == key_fp_i);

  always_comb begin
    match_d = match_q;
    if (clear_i) begin
      match_d.a_hit = 1'b0;
      match_d.f_hit = 1'b0;
    end else if (vld_i) begin
      if (!match_q.a_hit && addr_eq) begin
        match_d.a_hit    = 1'b1;
        match_d.a_fp_eq  = fp_eq;
        match_d.a_idx    = idx_i;
        match_d.a_shares = entry_i.shares;
      end
      if (!match_q.f_hit && fp_eq) begin
        match_d.f_hit    = 1'b1;
        match_d.f_idx    = idx_i;
        match_d.f_client = entry_i.client;
        match_d.f_inode  = entry_i.inode;
        match_d.f_shares = entry_i.shares;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= '0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_o = match_q;

endmodule

// ===== src/dedup_fingerprint_table_unit.sv =====
// ----------------------------------------------------------------------------
// Deduplication fingerprint table unit
// Looks up file records in a fingerprint table held in one RAM and reports
// whether each record is unchanged, updated, redirected, stored or rejected.
// ----------------------------------------------------------------------------
// One record is taken at a time. The table RAM has a single read port, so
// every record costs one read of each occupied slot. Slots fill in index
// order and are never freed, so the fill count alone marks which slots are
// valid and no clearing pass is needed after reset. A finished result waits
// in the output register while the next record is accepted; a result that
// finds the previous one still waiting holds until that beat leaves.
module dedup_fingerprint_table_unit import dftu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // s_axis_tdata: client_address, inode, fingerprint (from bit 0 up)
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tlast,
  // m_axis_tdata: action, target_client, target_inode, slot_index,
  // request_redirect, zero fill (from bit 0 up)
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic                 m_axis_tlast
);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]           key_client_q, key_inode_q;
  logic [FINGERPRINT_BITS-1:0] key_fp_q;
  logic                        key_last_q;

  logic [CNT_W-1:0] issue_q, issue_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             seen_q, seen_d;

  logic [M_FIELDS_W-1:0] res_q;
  logic                  res_last_q;
  logic                  m_tvalid_q, m_tvalid_d;
  logic [M_TDATA_W-1:0]  m_tdata_q;
  logic                  m_tlast_q;

  logic             accept, rd_en, out_free;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_entry;
  match_t           match;

  action_e           action;
  logic [IDX_W-1:0]  slot;
  logic [ADDR_W-1:0] tgt_client, tgt_inode;
  logic              redir, wr_en, req_redirect;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_entry;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign rd_en    = (state_q == ST_SCAN) && (issue_q < used_q);
  assign rd_addr  = issue_q[IDX_W-1:0];
  assign out_free = !m_tvalid_q || m_axis_tready;

  dftu_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_entry),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_entry)
  );

  dftu_match u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (accept),
    .vld_i       (cmp_vld_q),
    .idx_i       (cmp_idx_q),
    .entry_i     (rd_entry),
    .key_client_i(key_client_q),
    .key_inode_i (key_inode_q),
    .key_fp_i    (key_fp_q),
    .match_o     (match)
  );

  always_comb begin
    action     = ACT_FULL;
    slot       = '0;
    tgt_client = '0;
    tgt_inode  = '0;
    redir      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = match.f_idx;
    wr_entry   = '{shares: sat_inc(match.f_shares), fp: key_fp_q,
                   inode: match.f_inode, client: match.f_client};
    if (match.a_hit && match.a_fp_eq) begin
      action = ACT_UNCHANGED;
      slot   = match.a_idx;
    end else if (match.f_hit) begin
      action     = match.a_hit ? ACT_REDIR_CHANGE : ACT_REDIR_NEW;
      slot       = match.f_idx;
      tgt_client = match.f_client;
      tgt_inode  = match.f_inode;
      redir      = 1'b1;
      wr_en      = 1'b1;
    end else if (match.a_hit) begin
      action   = ACT_UPDATED;
      slot     = match.a_idx;
      wr_en    = 1'b1;
      wr_addr  = match.a_idx;
      wr_entry = '{shares: match.a_shares, fp: key_fp_q,
                   inode: key_inode_q, client: key_client_q};
    end else if (used_q < CNT_W'(TABLE_ENTRIES)) begin
      action   = ACT_STORED;
      slot     = used_q[IDX_W-1:0];
      wr_en    = 1'b1;
      wr_addr  = used_q[IDX_W-1:0];
      wr_entry = '{shares: '0, fp: key_fp_q,
                   inode: key_inode_q, client: key_client_q};
    end
    if (state_q != ST_DECIDE) begin
      wr_en = 1'b0;
    end
  end

  assign req_redirect = key_last_q && (seen_q || redir);

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    issue_d       = issue_q;
    cmp_vld_d     = 1'b0;
    used_d        = used_q;
    seen_d        = seen_q;
    m_tvalid_d    = m_axis_tready ? 1'b0 : m_tvalid_q;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        issue_d       = '0;
        if (s_axis_tvalid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_d   = issue_q + CNT_W'(1);
          cmp_vld_d = 1'b1;
        end else if (!cmp_vld_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (action == ACT_STORED) begin
          used_d = used_q + CNT_W'(1);
        end
        seen_d  = key_last_q ? 1'b0 : (seen_q || redir);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      issue_q    <= '0;
      cmp_vld_q  <= 1'b0;
      used_q     <= '0;
      seen_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      issue_q    <= issue_d;
      cmp_vld_q  <= cmp_vld_d;
      used_q     <= used_d;
      seen_q     <= seen_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_client_q <= s_axis_tdata[0 +: ADDR_W];
      key_inode_q  <= s_axis_tdata[ADDR_W +: ADDR_W];
      key_fp_q     <= s_axis_tdata[2 * ADDR_W +: FINGERPRINT_BITS];
      key_last_q   <= s_axis_tlast;
    end
    cmp_idx_q <= rd_addr;
    if (state_q == ST_DECIDE) begin
      res_q      <= {req_redirect, SLOT_OUT_W'(slot), tgt_inode, tgt_client, action};
      res_last_q <= key_last_q;
    end
    if ((state_q == ST_OUT) && out_free) begin
      m_tdata_q <= M_TDATA_W'(res_q);
      m_tlast_q <= res_last_q;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tlast  = m_tlast_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count exceeds table size");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (issue_q < used_q) && (state_q == ST_SCAN))
    else $error("scan read beyond occupied slots");

  a_store_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && action == ACT_STORED) |=>
      used_q == $past(used_q) + CNT_W'(1))
    else $error("stored record did not advance fill count");

  a_beat_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
    else $error("output beat raised outside result hand-off");

endmodule
